// ===== hw/rtl/mipsex_pkg.sv =====
// Shared types, constants and the opcode decoder of the MIPS I-type/J-type executor.
package mipsex_pkg;

  localparam int unsigned DATA_BYTES_DEF = 4096;
  localparam logic [31:0] RESET_START    = 32'h0040_0000;
  localparam logic [31:0] JUMP_REGION    = 32'hF000_0000;
  localparam logic [4:0]  LINK_REG       = 5'd31;

  typedef enum logic [5:0] {
    OP_J         = 6'h02,
    OP_JAL       = 6'h03,
    OP_BEQ       = 6'h04,
    OP_BNE       = 6'h05,
    OP_ADDI      = 6'h08,
    OP_ADD_IMM_U = 6'h09,
    OP_SLTI      = 6'h0A,
    OP_SLT_IMM_U = 6'h0B,
    OP_ANDI      = 6'h0C,
    OP_ORI       = 6'h0D,
    OP_XORI      = 6'h0E,
    OP_LUI       = 6'h0F,
    OP_LB        = 6'h20,
    OP_LH        = 6'h21,
    OP_LW        = 6'h23,
    OP_LBU       = 6'h24,
    OP_LHU       = 6'h25,
    OP_SB        = 6'h28,
    OP_SH        = 6'h29,
    OP_SW        = 6'h2B
  } opcode_e;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SLT,
    ALU_SLTU,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_EQ,
    ALU_PASSB,
    ALU_SUBGE,
    ALU_MULHI,
    ALU_MULLO
  } alu_op_e;

  typedef enum logic [2:0] {
    CL_NOP,
    CL_JUMP,
    CL_BRANCH,
    CL_ALU,
    CL_LOAD,
    CL_STORE
  } class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PC4,
    ST_EXEC,
    ST_BRANCH,
    ST_REDUCE,
    ST_MEM,
    ST_WB
  } state_e;

  typedef struct packed {
    class_e      cls;
    alu_op_e     op;
    logic        zimm;
    logic        lui;
    logic        link;
    logic        bne;
    logic        sext;
    logic [2:0]  nbytes;
  } dec_t;

  function automatic dec_t decode(logic [5:0] opc);
    dec_t d;
    d.cls    = CL_NOP;
    d.op     = ALU_ADD;
    d.zimm   = 1'b0;
    d.lui    = 1'b0;
    d.link   = 1'b0;
    d.bne    = 1'b0;
    d.sext   = 1'b0;
    d.nbytes = 3'd0;
    case (opc)
      OP_J: begin
        d.cls = CL_JUMP;
      end
      OP_JAL: begin
        d.cls  = CL_JUMP;
        d.link = 1'b1;
      end
      OP_BEQ: begin
        d.cls = CL_BRANCH;
        d.op  = ALU_EQ;
      end
      OP_BNE: begin
        d.cls = CL_BRANCH;
        d.op  = ALU_EQ;
        d.bne = 1'b1;
      end
      OP_ADDI, OP_ADD_IMM_U: begin
        d.cls = CL_ALU;
      end
      OP_SLTI: begin
        d.cls = CL_ALU;
        d.op  = ALU_SLT;
      end
      OP_SLT_IMM_U: begin
        d.cls = CL_ALU;
        d.op  = ALU_SLTU;
      end
      OP_ANDI: begin
        d.cls  = CL_ALU;
        d.op   = ALU_AND;
        d.zimm = 1'b1;
      end
      OP_ORI: begin
        d.cls  = CL_ALU;
        d.op   = ALU_OR;
        d.zimm = 1'b1;
      end
      OP_XORI: begin
        d.cls  = CL_ALU;
        d.op   = ALU_XOR;
        d.zimm = 1'b1;
      end
      OP_LUI: begin
        d.cls = CL_ALU;
        d.op  = ALU_PASSB;
        d.lui = 1'b1;
      end
      OP_LB: begin
        d.cls    = CL_LOAD;
        d.sext   = 1'b1;
        d.nbytes = 3'd1;
      end
      OP_LH: begin
        d.cls    = CL_LOAD;
        d.sext   = 1'b1;
        d.nbytes = 3'd2;
      end
      OP_LW: begin
        d.cls    = CL_LOAD;
        d.nbytes = 3'd4;
      end
      OP_LBU: begin
        d.cls    = CL_LOAD;
        d.nbytes = 3'd1;
      end
      OP_LHU: begin
        d.cls    = CL_LOAD;
        d.nbytes = 3'd2;
      end
      OP_SB: begin
        d.cls    = CL_STORE;
        d.nbytes = 3'd1;
      end
      OP_SH: begin
        d.cls    = CL_STORE;
        d.nbytes = 3'd2;
      end
      OP_SW: begin
        d.cls    = CL_STORE;
        d.nbytes = 3'd4;
      end
      default: begin
        d.cls = CL_NOP;
      end
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/mipsex_alu.sv =====
// Shared 32-bit arithmetic, logic and compare unit of the executor.
module mipsex_alu
  import mipsex_pkg::*;
(
  input  alu_op_e     op_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic [31:0] res_o
);

  logic [63:0] prod;

  assign prod = 64'(x_i) * 64'(y_i);

  always_comb begin
    unique case (op_i)
      ALU_ADD:   res_o = x_i + y_i;
      ALU_SLT:   res_o = {31'b0, $signed(x_i) < $signed(y_i)};
      ALU_SLTU:  res_o = {31'b0, x_i < y_i};
      ALU_AND:   res_o = x_i & y_i;
      ALU_OR:    res_o = x_i | y_i;
      ALU_XOR:   res_o = x_i ^ y_i;
      ALU_EQ:    res_o = {31'b0, x_i == y_i};
      ALU_PASSB: res_o = y_i;
      // Subtract only when the result stays non-negative.
      ALU_SUBGE: res_o = (x_i >= y_i) ? (x_i - y_i) : x_i;
      ALU_MULHI: res_o = prod[63:32];
      ALU_MULLO: res_o = prod[31:0];
      default:   res_o = 32'b0;
    endcase
  end

endmodule

// ===== hw/rtl/mipsex_dmem.sv =====
// Byte-wide data memory with a clearing pass after reset.
module mipsex_dmem
  import mipsex_pkg::*;
#(
  parameter int unsigned DataBytes = DATA_BYTES_DEF,
  localparam int unsigned Aw = $clog2(DataBytes)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_en_i,
  input  logic          acc_we_i,
  input  logic [Aw-1:0] acc_idx_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o,
  output logic          clearing_o
);

  localparam logic [Aw-1:0] IdxLast = Aw'(DataBytes - 1);

  logic [7:0]    mem [DataBytes];
  logic          clr_q, clr_d;
  logic [Aw-1:0] clr_idx_q, clr_idx_d;
  logic [7:0]    rdata_q;

  always_comb begin
    clr_d     = clr_q;
    clr_idx_d = clr_idx_q;
    if (clr_q) begin
      clr_idx_d = clr_idx_q + Aw'(1);
      if (clr_idx_q == IdxLast) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_idx_q] <= 8'h00;
    end else if (acc_en_i && acc_we_i) begin
      mem[acc_idx_i] <= wdata_i;
    end
    rdata_q <= mem[acc_idx_i];
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

// ===== hw/rtl/mips_itype_jtype_execute_top.sv =====
// Top level of the MIPS I-type/J-type instruction executor.
// Sequence: an instruction word passes a PC+4 step, an execute step, a branch-target step
// for a branch, and for a load or store the remainder steps when DATA_BYTES is not a power
// of two and one access of the byte-wide memory port per byte, then a write-back step.
// Throughput: one word at a time; the next word is taken the cycle after a result is registered.
// Reset: registers read as zero, the counter loads 0x00400000, and the data memory is cleared
// by a pass over every byte, during which no instruction word is accepted.
module mips_itype_jtype_execute_top
  import mipsex_pkg::*;
#(
  parameter int unsigned DATA_BYTES = DATA_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Instruction channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] next_pc_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        mem_written_o,
  output logic [31:0] mem_address_o,
  output logic        unsupported_o,
  // Configuration channel: start address.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] start_address_i
);

  localparam int unsigned Aw = $clog2(DATA_BYTES);
  // A power-of-two memory folds an address by keeping its low bits; any other size
  // takes a reciprocal multiply, a back-multiply and one correcting subtraction.
  localparam bit Pow2 = (DATA_BYTES == (1 << Aw));
  localparam logic [Aw-1:0] IdxLast = Aw'(DATA_BYTES - 1);
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(DATA_BYTES));

  // Sequencer and control state.
  state_e        state_q, state_d;
  logic [31:0]   pc_q;
  logic [2:0]    k_q;
  logic [1:0]    cnt_q;
  logic          out_valid_q;
  logic [31:0]   rf_valid_q;

  // Datapath registers.
  logic [31:0]   instr_q;
  logic [31:0]   rda_q, rdb_q;
  logic          va_q, vb_q;
  logic [31:0]   pc4_q, npc_q, res_q, val_q, sh_q, ea_run_q;
  logic [Aw-1:0] idx_q;
  logic          pend_q;
  logic [31:0]   rf [32];

  // Result register.
  logic [31:0]   next_pc_q, reg_value_q, mem_address_q;
  logic          reg_written_q, mem_written_q, unsupported_q;
  logic [4:0]    reg_index_q;

  dec_t          dec;
  logic [31:0]   reg_a, reg_b, simm, zimm;
  logic [15:0]   imm;
  logic [4:0]    rt;

  alu_op_e       alu_op;
  logic [31:0]   alu_x, alu_y, alu_res;

  logic          acc_en, acc_we, clearing;
  logic [7:0]    rdata;
  logic [Aw-1:0] idx_nxt;

  logic          taken, memop, wb_adv, wr, accept;
  logic [4:0]    widx;
  logic [31:0]   wval, store_al, load_ext;

  assign dec   = decode(instr_q[31:26]);
  assign imm   = instr_q[15:0];
  assign rt    = instr_q[20:16];
  assign simm  = {{16{imm[15]}}, imm};
  assign zimm  = {16'b0, imm};
  assign reg_a = va_q ? rda_q : 32'b0;
  assign reg_b = vb_q ? rdb_q : 32'b0;
  assign memop = (dec.cls == CL_LOAD) || (dec.cls == CL_STORE);
  assign taken = dec.bne ? !res_q[0] : res_q[0];

  assign in_ready_o  = (state_q == ST_IDLE) && !clearing;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign wb_adv      = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_PC4;
      ST_PC4:    state_d = ST_EXEC;
      ST_EXEC: begin
        if (dec.cls == CL_BRANCH) begin
          state_d = ST_BRANCH;
        end else if (memop) begin
          state_d = Pow2 ? ST_MEM : ST_REDUCE;
        end else begin
          state_d = ST_WB;
        end
      end
      ST_BRANCH: state_d = ST_WB;
      ST_REDUCE: if (cnt_q == 2'd0) state_d = ST_MEM;
      ST_MEM:    if (k_q == dec.nbytes) state_d = ST_WB;
      ST_WB:     if (wb_adv) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Operand selection for the shared unit and the memory port in each state.
  always_comb begin
    alu_op = ALU_ADD;
    alu_x  = 32'b0;
    alu_y  = 32'b0;
    acc_en = 1'b0;
    acc_we = 1'b0;
    unique case (state_q)
      ST_PC4: begin
        alu_x = pc_q;
        alu_y = 32'd4;
      end
      ST_EXEC: begin
        alu_op = dec.op;
        alu_x  = reg_a;
        if (dec.cls == CL_BRANCH) begin
          alu_y = reg_b;
        end else if (dec.lui) begin
          alu_y = {imm, 16'b0};
        end else if (dec.zimm) begin
          alu_y = zimm;
        end else begin
          alu_y = simm;
        end
      end
      ST_BRANCH: begin
        alu_x = pc4_q;
        alu_y = {simm[29:0], 2'b00};
      end
      ST_REDUCE: begin
        // Quotient estimate from the reciprocal is low by at most one, so the
        // difference left after the back-multiply needs one conditional subtract.
        unique case (cnt_q)
          2'd3: begin
            alu_op = ALU_MULHI;
            alu_x  = ea_run_q;
            alu_y  = Recip;
          end
          2'd2: begin
            alu_op = ALU_MULLO;
            alu_x  = val_q;
            alu_y  = 32'(DATA_BYTES);
          end
          2'd1: begin
            alu_op = ALU_SUBGE;
            alu_x  = ea_run_q;
            alu_y  = val_q;
          end
          2'd0: begin
            alu_op = ALU_SUBGE;
            alu_x  = val_q;
            alu_y  = 32'(DATA_BYTES);
          end
        endcase
      end
      ST_MEM: begin
        acc_en = (k_q != dec.nbytes);
        acc_we = (dec.cls == CL_STORE);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  mipsex_alu u_alu (
    .op_i  (alu_op),
    .x_i   (alu_x),
    .y_i   (alu_y),
    .res_o (alu_res)
  );

  mipsex_dmem #(
    .DataBytes (DATA_BYTES)
  ) u_dmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_en_i   (acc_en),
    .acc_we_i   (acc_we),
    .acc_idx_i  (idx_q),
    .wdata_i    (sh_q[31:24]),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  // Byte k+1 of an access follows byte k, wrapping at the end of the memory and again
  // where the 32-bit address itself wraps to zero.
  assign idx_nxt = ((ea_run_q == 32'hFFFF_FFFF) || (idx_q == IdxLast)) ? '0 : idx_q + Aw'(1);

  // Store data is left-aligned so that the most significant byte goes out first.
  always_comb begin
    unique case (dec.nbytes)
      3'd1:    store_al = {reg_b[7:0], 24'b0};
      3'd2:    store_al = {reg_b[15:0], 16'b0};
      default: store_al = reg_b;
    endcase
  end

  always_comb begin
    unique case (dec.nbytes)
      3'd1:    load_ext = {{24{dec.sext & val_q[7]}}, val_q[7:0]};
      3'd2:    load_ext = {{16{dec.sext & val_q[15]}}, val_q[15:0]};
      default: load_ext = val_q;
    endcase
  end

  // Write-back decision. A write aimed at register zero is dropped entirely.
  always_comb begin
    widx = dec.link ? LINK_REG : rt;
    wr   = (dec.cls == CL_ALU) || (dec.cls == CL_LOAD) || dec.link;
    if (widx == 5'd0) begin
      wr = 1'b0;
    end
    if (dec.link) begin
      wval = pc4_q;
    end else if (dec.cls == CL_LOAD) begin
      wval = load_ext;
    end else begin
      wval = res_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= RESET_START;
      k_q         <= 3'd0;
      cnt_q       <= 2'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rf_valid_q  <= 32'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pc_q <= start_address_i;
      end else if (state_q == ST_WB && wb_adv) begin
        pc_q <= npc_q;
      end
      if (state_q == ST_EXEC) begin
        k_q   <= 3'd0;
        cnt_q <= 2'd3;
      end else if (state_q == ST_REDUCE) begin
        cnt_q <= cnt_q - 2'd1;
      end else if (acc_en) begin
        k_q <= k_q + 3'd1;
      end
      pend_q <= acc_en && !acc_we;
      if (state_q == ST_WB && wb_adv) begin
        out_valid_q <= 1'b1;
        if (wr) begin
          rf_valid_q[widx] <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Register file: two registered read ports, one write port.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      rda_q   <= rf[instruction_i[25:21]];
      rdb_q   <= rf[instruction_i[20:16]];
      va_q    <= rf_valid_q[instruction_i[25:21]];
      vb_q    <= rf_valid_q[instruction_i[20:16]];
      instr_q <= instruction_i;
    end
    if (state_q == ST_WB && wb_adv && wr) begin
      rf[widx] <= wval;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_PC4: begin
        pc4_q <= alu_res;
      end
      ST_EXEC: begin
        res_q    <= alu_res;
        npc_q    <= (dec.cls == CL_JUMP) ?
                    ((pc4_q & JUMP_REGION) | {4'b0, instr_q[25:0], 2'b00}) : pc4_q;
        ea_run_q <= alu_res;
        idx_q    <= alu_res[Aw-1:0];
        sh_q     <= store_al;
        val_q    <= 32'b0;
      end
      ST_BRANCH: begin
        if (taken) begin
          npc_q <= alu_res;
        end
      end
      ST_REDUCE: begin
        if (cnt_q == 2'd0) begin
          idx_q <= alu_res[Aw-1:0];
          val_q <= 32'b0;
        end else begin
          val_q <= alu_res;
        end
      end
      ST_MEM: begin
        if (acc_en) begin
          idx_q    <= idx_nxt;
          ea_run_q <= ea_run_q + 32'd1;
          sh_q     <= {sh_q[23:0], 8'h00};
        end
        if (pend_q) begin
          val_q <= {val_q[23:0], rdata};
        end
      end
      default: begin
        pc4_q <= pc4_q;
      end
    endcase
  end

  // Result register: loaded at write-back, held until the word is taken.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_WB && wb_adv) begin
      next_pc_q     <= npc_q;
      reg_written_q <= wr;
      reg_index_q   <= wr ? widx : 5'd0;
      reg_value_q   <= wr ? wval : 32'b0;
      mem_written_q <= (dec.cls == CL_STORE);
      mem_address_q <= memop ? res_q : 32'b0;
      unsupported_q <= (dec.cls == CL_NOP);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_pc_o     = next_pc_q;
  assign reg_written_o = reg_written_q;
  assign reg_index_o   = reg_index_q;
  assign reg_value_o   = reg_value_q;
  assign mem_written_o = mem_written_q;
  assign mem_address_o = mem_address_q;
  assign unsupported_o = unsupported_q;

  // No instruction word is taken while the memory is still being cleared.
  a_no_accept_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_ready_o)
    else $error("instruction accepted during memory clear");

  // The memory port is only driven from the access state.
  a_mem_access_in_mem_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_en |-> (state_q == ST_MEM) && !clearing)
    else $error("memory access outside the access state");

  // Register zero is never reported as written.
  a_reg_zero_dropped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reg_written_o == (reg_index_o != 5'd0)))
    else $error("register write report inconsistent");

  // An unsupported instruction has no side effects beyond the counter.
  a_unsupported_noop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unsupported_o |-> !reg_written_o && !mem_written_o
                                     && (mem_address_o == 32'b0))
    else $error("unsupported instruction had side effects");

  // The byte counter never runs past a word.
  a_byte_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MEM) |-> (k_q <= 3'd4))
    else $error("byte counter out of range");

endmodule
